FILE: rtl/core/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared constants for the slew ramp with dwell timer and auto-return.
// ----------------------------------------------------------------------------
package sra_pkg;

    // default fraction bits of the position and time formats
    localparam int FRAC_BITS_DEF = 16;
    // integer bits of the time format (Q8.FRAC_BITS seconds)
    localparam int TIME_INT_BITS = 8;

    // request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 1'b1;

endpackage

FILE: rtl/core/sra_div.sv
// ----------------------------------------------------------------------------
// sra_div
// Radix-2 restoring divider: step size = (dividend << FRAC_BITS) / divisor,
// or one at two and up. One quotient bit per cycle on a shared subtractor.
// ----------------------------------------------------------------------------
module sra_div #(
    parameter int FRAC_BITS = sra_pkg::FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [FRAC_BITS+sra_pkg::TIME_INT_BITS-1:0] dividend,
    input  logic [FRAC_BITS+sra_pkg::TIME_INT_BITS-1:0] divisor,
    output logic                                        done,
    output logic [FRAC_BITS:0]                          quotient
);
    import sra_pkg::*;

    localparam int TIME_W = FRAC_BITS + TIME_INT_BITS;
    localparam int POS_W  = FRAC_BITS + 1;
    localparam int TOP    = FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 2);
    localparam logic [POS_W-1:0] ONE_C = {1'b1, {FRAC_BITS{1'b0}}};

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W:0]   rem_reg, rem_next;
    logic [TIME_W-1:0] dsr_reg, dsr_next;
    logic [POS_W-1:0]  quo_reg, quo_next;

    logic              phase_a, phase_b;
    logic [TIME_W+1:0] op_a, op_b;
    logic [TIME_W+2:0] diff;
    logic              ge;

    // first pass checks for overflow against twice the divisor,
    // second pass gives the integer bit, the rest shift in zeros
    assign phase_a = (cnt_reg == CNT_W'(TOP));
    assign phase_b = (cnt_reg == CNT_W'(TOP - 1));
    assign op_a = (phase_a || phase_b) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign op_b = phase_a ? {1'b0, dsr_reg, 1'b0} : {2'b00, dsr_reg};
    assign diff = {1'b0, op_a} - {1'b0, op_b};
    assign ge   = !diff[TIME_W+2];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TOP);
            rem_next  = {1'b0, dividend};
            dsr_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[TIME_W:0] : op_a[TIME_W:0];
            if (phase_a)
            begin
                if (ge)
                begin
                    quo_next  = ONE_C;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                quo_next = {quo_reg[POS_W-2:0], ge};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/slew_ramp_auto_return.sv
// ----------------------------------------------------------------------------
// slew_ramp_auto_return
// Slew-rate limited position with dwell timer and automatic return to zero.
// ----------------------------------------------------------------------------
// One request at a time. A set request or a tick with zero elapsed time goes
// straight to the output state. A tick with nonzero elapsed time first waits
// for the step size from a radix-2 divider that makes an overflow pass and
// then one quotient bit per cycle, FRAC_BITS+2 passes in all, and flags
// completion from a register; it stops after the first pass when the elapsed
// time is at least twice the travel time. The position move, the dwell timer
// update and the result load follow in their own states, in that order; the
// load waits while an earlier result is untaken. A finished result sits in an
// output register, so the next request can be accepted while it waits to be taken.
module slew_ramp_auto_return #(
    parameter int FRAC_BITS = sra_pkg::FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic                                        req_type,
    input  logic [FRAC_BITS+sra_pkg::TIME_INT_BITS-1:0] elapsed,
    input  logic [FRAC_BITS:0]                          new_target,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [FRAC_BITS:0]                          position,
    output logic [FRAC_BITS:0]                          goal,
    output logic                                        auto_returned,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [sra_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [FRAC_BITS+sra_pkg::TIME_INT_BITS-1:0] cfg_data
);
    import sra_pkg::*;

    localparam int TIME_W = FRAC_BITS + TIME_INT_BITS;
    localparam int POS_W  = FRAC_BITS + 1;

    localparam int ONE_V     = 1 << FRAC_BITS;
    localparam int DEF_DUR_V = (ONE_V * 4 + 2) / 5;
    localparam int MIN_DUR_V = (ONE_V + 9999) / 10000;
    localparam int HALF_V    = ONE_V / 2;
    localparam int NEAR_V    = ONE_V - ONE_V / 1000;

    localparam logic [POS_W-1:0]  ONE_C     = POS_W'(ONE_V);
    localparam logic [POS_W-1:0]  HALF_C    = POS_W'(HALF_V);
    localparam logic [POS_W-1:0]  NEAR_C    = POS_W'(NEAR_V);
    localparam logic [TIME_W-1:0] DEF_DUR_C = TIME_W'(DEF_DUR_V);
    localparam logic [TIME_W-1:0] MIN_DUR_C = TIME_W'(MIN_DUR_V);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_DWELL = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [TIME_W-1:0] duration_reg, duration_next;
    logic [TIME_W-1:0] delay_reg, delay_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [POS_W-1:0]  target_reg, target_next;
    logic [TIME_W-1:0] dwell_reg, dwell_next;
    logic              ret_reg, ret_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [POS_W-1:0]  out_goal_reg, out_goal_next;
    logic              out_ret_reg, out_ret_next;

    logic              in_accept;
    logic              cfg_accept;
    logic              tick_go;
    logic [TIME_W-1:0] dur_eff;
    logic              div_done;
    logic [POS_W-1:0]  div_quo;
    logic [POS_W-1:0]  step;
    logic [POS_W:0]    up_sum;
    logic [POS_W-1:0]  gap;
    logic [TIME_W:0]   dwell_sum;
    logic [TIME_W-1:0] dwell_sat;
    logic              dwell_on;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign tick_go    = in_accept && (req_type == REQ_TICK) && (elapsed != '0);

    // very short travel times fall back to the default
    assign dur_eff = (duration_reg < MIN_DUR_C) ? DEF_DUR_C : duration_reg;

    sra_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_go),
        .dividend (elapsed),
        .divisor  (dur_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign step      = (div_quo > ONE_C) ? ONE_C : div_quo;
    assign up_sum    = {1'b0, position_reg} + {1'b0, step};
    assign gap       = position_reg - target_reg;
    assign dwell_sum = {1'b0, dwell_reg} + {1'b0, elapsed_reg};
    assign dwell_sat = dwell_sum[TIME_W] ? {TIME_W{1'b1}} : dwell_sum[TIME_W-1:0];
    assign dwell_on  = (delay_reg != '0) && (target_reg >= HALF_C)
                       && (position_reg >= NEAR_C);

    always_comb
    begin
        state_next     = state_reg;
        duration_next  = duration_reg;
        delay_next     = delay_reg;
        position_next  = position_reg;
        target_next    = target_reg;
        dwell_next     = dwell_reg;
        ret_next       = ret_reg;
        elapsed_next   = elapsed_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_goal_next  = out_goal_reg;
        out_ret_next   = out_ret_reg;

        if (cfg_accept)
        begin
            case (cfg_index)
                CFG_DURATION: duration_next = cfg_data;
                CFG_DELAY:    delay_next    = cfg_data;
                default:      ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    ret_next     = 1'b0;
                    elapsed_next = elapsed;
                    if (req_type == REQ_SET)
                    begin
                        target_next = (new_target > ONE_C) ? ONE_C : new_target;
                        state_next  = S_OUT;
                    end
                    else if (tick_go)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                // move toward the target without passing it
                if (position_reg < target_reg)
                begin
                    position_next = (up_sum > {1'b0, target_reg}) ? target_reg
                                                                   : up_sum[POS_W-1:0];
                end
                else if (position_reg > target_reg)
                begin
                    position_next = (gap <= step) ? target_reg : position_reg - step;
                end
                state_next = S_DWELL;
            end
            S_DWELL:
            begin
                if (dwell_on)
                begin
                    if (dwell_sat >= delay_reg)
                    begin
                        target_next = '0;
                        dwell_next  = '0;
                        ret_next    = 1'b1;
                    end
                    else
                    begin
                        dwell_next = dwell_sat;
                    end
                end
                else
                begin
                    dwell_next = '0;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = position_reg;
                    out_goal_next  = target_reg;
                    out_ret_next   = ret_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            duration_reg  <= DEF_DUR_C;
            delay_reg     <= '0;
            position_reg  <= '0;
            target_reg    <= '0;
            dwell_reg     <= '0;
            ret_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            duration_reg  <= duration_next;
            delay_reg     <= delay_next;
            position_reg  <= position_next;
            target_reg    <= target_next;
            dwell_reg     <= dwell_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg  <= elapsed_next;
        out_pos_reg  <= out_pos_next;
        out_goal_reg <= out_goal_next;
        out_ret_reg  <= out_ret_next;
    end

    assign out_valid     = out_valid_reg;
    assign position      = out_pos_reg;
    assign goal          = out_goal_reg;
    assign auto_returned = out_ret_reg;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("request accepted while a previous one is in flight");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (position_reg <= ONE_C) && (target_reg <= ONE_C))
        else $error("position or target beyond full travel");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide phase");

    a_return_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DWELL && ret_next) |=> (dwell_reg == '0 && target_reg == '0))
        else $error("auto-return did not clear timer and target");

    a_returned_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ret_reg) |-> (out_goal_reg == '0))
        else $error("auto-return reported with nonzero goal");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ramp targets and time ticks into slew_ramp_auto_return, mirrors the
// ramp, dwell timer and auto-return in a local model, and checks every
// position, goal and return flag under random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import sra_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int TW = FB + TIME_INT_BITS;
    localparam int PW = FB + 1;
    localparam int CLK_HALF = 5;
    localparam longint unsigned ONE = 64'd1 << FB;
    localparam longint unsigned DEF_DUR = (ONE * 4 + 2) / 5;
    localparam longint unsigned MIN_DUR = (ONE + 9999) / 10000;
    localparam longint unsigned HALF = ONE >> 1;
    localparam longint unsigned NEAR_FULL = ONE - ONE / 1000;
    localparam longint unsigned TIME_MAX = (64'd1 << TW) - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * (FB + 6);
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 175;

    typedef struct packed {
        logic [PW-1:0] pos;
        logic [PW-1:0] goal;
        logic          returned;
    } ramp_out_t;

    typedef enum logic [1:0] {ROW_TICK, ROW_SET, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [TW-1:0]          value;
        logic                   pinned;
        ramp_out_t              want;
    } stim_row_t;

    // pinned rows carry the result that follows directly from the request
    localparam stim_row_t DIRECTED [26] = '{
        '{ROW_TICK, CFG_DURATION, 0,          1'b1, '{0, 0, 1'b0}},
        '{ROW_SET,  CFG_DURATION, 65536,      1'b1, '{0, 65536, 1'b0}},
        // target above one saturates
        '{ROW_SET,  CFG_DURATION, 131071,     1'b1, '{0, 65536, 1'b0}},
        '{ROW_TICK, CFG_DURATION, 1,          1'b0, '{0, 0, 1'b0}},
        '{ROW_TICK, CFG_DURATION, 0,          1'b0, '{0, 0, 1'b0}},
        '{ROW_TICK, CFG_DURATION, 24'hFFFFFF, 1'b1, '{65536, 65536, 1'b0}},
        '{ROW_SET,  CFG_DURATION, 0,          1'b1, '{65536, 0, 1'b0}},
        '{ROW_TICK, CFG_DURATION, 1000,       1'b0, '{0, 0, 1'b0}},
        '{ROW_TICK, CFG_DURATION, 24'hFFFFFF, 1'b1, '{0, 0, 1'b0}},
        // zero duration falls back to the default
        '{ROW_CFG,  CFG_DURATION, 0,          1'b0, '{0, 0, 1'b0}},
        '{ROW_CFG,  CFG_DELAY,    1,          1'b0, '{0, 0, 1'b0}},
        '{ROW_SET,  CFG_DURATION, 65536,      1'b1, '{0, 65536, 1'b0}},
        '{ROW_TICK, CFG_DURATION, 24'hFFFFFF, 1'b1, '{65536, 0, 1'b1}},
        '{ROW_TICK, CFG_DURATION, 6,          1'b0, '{0, 0, 1'b0}},
        '{ROW_CFG,  CFG_DURATION, 7,          1'b0, '{0, 0, 1'b0}},
        '{ROW_CFG,  CFG_DELAY,    24'hFFFFFF, 1'b0, '{0, 0, 1'b0}},
        '{ROW_SET,  CFG_DURATION, 65536,      1'b0, '{0, 0, 1'b0}},
        // second tick overflows the dwell timer
        '{ROW_TICK, CFG_DURATION, 24'h800000, 1'b0, '{0, 0, 1'b0}},
        '{ROW_TICK, CFG_DURATION, 24'hFFFFFF, 1'b0, '{0, 0, 1'b0}},
        '{ROW_CFG,  CFG_DURATION, 24'hFFFFFF, 1'b0, '{0, 0, 1'b0}},
        '{ROW_SET,  CFG_DURATION, 32768,      1'b0, '{0, 0, 1'b0}},
        '{ROW_TICK, CFG_DURATION, 24'h00FFFF, 1'b0, '{0, 0, 1'b0}},
        // step truncates to zero
        '{ROW_TICK, CFG_DURATION, 1,          1'b0, '{0, 0, 1'b0}},
        '{ROW_CFG,  CFG_DURATION, 6,          1'b0, '{0, 0, 1'b0}},
        '{ROW_TICK, CFG_DURATION, 100,        1'b0, '{0, 0, 1'b0}},
        '{ROW_CFG,  CFG_DELAY,    0,          1'b0, '{0, 0, 1'b0}}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 req_type = REQ_TICK;
    logic [TW-1:0]        elapsed = '0;
    logic [PW-1:0]        new_target = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PW-1:0]        position;
    logic [PW-1:0]        goal;
    logic                 auto_returned;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DURATION;
    logic [TW-1:0]        cfg_data = '0;

    // result forced by a directed row, travels with the request
    logic                 req_pinned = 1'b0;
    ramp_out_t            req_want = '0;

    // local copy of the block state and registers
    logic [PW-1:0]        ramp_pos = '0;
    logic [PW-1:0]        ramp_goal = '0;
    logic [TW-1:0]        dwell_acc = '0;
    logic [TW-1:0]        cfg_travel = TW'(DEF_DUR);
    logic [TW-1:0]        cfg_delay = '0;

    ramp_out_t            ramp_expect [$];
    int                   mismatches = 0;
    int                   idle_cycles = 0;
    bit                   steady = 1'b0;

    slew_ramp_auto_return dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .elapsed      (elapsed),
        .new_target   (new_target),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .position     (position),
        .goal         (goal),
        .auto_returned(auto_returned),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic ramp_out_t ramp_advance(input logic kind, input logic [TW-1:0] dt,
                                               input logic [PW-1:0] tgt);
        longint unsigned dur;
        longint unsigned step;
        longint unsigned sum;
        ramp_out_t res;
        res.returned = 1'b0;
        if (kind == REQ_SET)
        begin
            ramp_goal = (tgt > ONE) ? PW'(ONE) : tgt;
        end
        else if (dt != '0)
        begin
            dur = (cfg_travel < MIN_DUR) ? DEF_DUR : cfg_travel;
            step = {40'd0, dt};
            step = (step << FB) / dur;
            if (step > ONE)
                step = ONE;
            if (ramp_pos < ramp_goal)
            begin
                sum = ramp_pos + step;
                ramp_pos = (sum > ramp_goal) ? ramp_goal : PW'(sum);
            end
            else if (ramp_pos > ramp_goal)
            begin
                sum = ramp_pos - ramp_goal;
                ramp_pos = (sum <= step) ? ramp_goal : PW'(ramp_pos - step);
            end
            // dwell runs only while parked near full with a high target
            if (cfg_delay != '0 && ramp_goal >= HALF && ramp_pos >= NEAR_FULL)
            begin
                sum = dwell_acc + dt;
                dwell_acc = (sum > TIME_MAX) ? TW'(TIME_MAX) : TW'(sum);
                if (dwell_acc >= cfg_delay)
                begin
                    ramp_goal = '0;
                    dwell_acc = '0;
                    res.returned = 1'b1;
                end
            end
            else
            begin
                dwell_acc = '0;
            end
        end
        res.pos = ramp_pos;
        res.goal = ramp_goal;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [PW-1:0] want_v,
                               input logic [PW-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // prediction, result check and watchdog
    always @(posedge clk)
    begin : scoreboard
        ramp_out_t pred;
        ramp_out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DURATION: cfg_travel = cfg_data;
                    CFG_DELAY:    cfg_delay = cfg_data;
                    default:      ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                pred = ramp_advance(req_type, elapsed, new_target);
                ramp_expect.push_back(req_pinned ? req_want : pred);
            end
            if (out_valid && out_ready)
            begin
                if (ramp_expect.size() == 0)
                begin
                    $display("%0t: unexpected result, position %0d goal %0d returned %0d",
                             $time, position, goal, auto_returned);
                    mismatches++;
                end
                else
                begin
                    want = ramp_expect.pop_front();
                    check_field("position", want.pos, position);
                    check_field("goal", want.goal, goal);
                    check_field("auto_returned", PW'(want.returned), PW'(auto_returned));
                end
            end
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("slew_ramp_auto_return test failed");
                $finish;
            end
        end
    end

    // output backpressure: mostly ready, short stalls, now and then a long one
    always @(posedge clk)
    begin : result_sink
        int r;
        int stall_left;
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (steady || r < 70)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b0;
                stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // zero, full scale, or a random value of random width
    function automatic logic [TW-1:0] pick_time();
        int r;
        int w;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return TW'(TIME_MAX);
        w = $urandom_range(1, TW);
        return TW'($urandom) >> (TW - w);
    endfunction

    function automatic logic [PW-1:0] pick_target();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6)
            return PW'(ONE);
        if (r < 10)
            return PW'($urandom_range(int'(ONE), int'(HALF)));
        if (r < 12)
            return '0;
        if (r < 14)
            return PW'($urandom_range((1 << PW) - 1, int'(ONE) + 1));
        return PW'($urandom);
    endfunction

    task automatic drain_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ramp_expect.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TW-1:0] data);
        drain_wait();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // valid stays up across back-to-back requests
    task automatic send_req(input logic kind, input logic [TW-1:0] value, input logic pin,
                            input ramp_out_t pin_val, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        if (kind == REQ_SET)
        begin
            new_target <= value[PW-1:0];
            elapsed <= TW'($urandom);
        end
        else
        begin
            elapsed <= value;
            new_target <= PW'($urandom);
        end
        req_pinned <= pin;
        req_want <= pin_val;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    initial
    begin : stimulus
        stim_row_t row;
        logic [TW-1:0] travel;
        logic [TW-1:0] delay;
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG)
                cfg_write(row.idx, row.value);
            else
                send_req(row.kind == ROW_SET ? REQ_SET : REQ_TICK, row.value, row.pinned,
                         row.want, pick_gap());
        end
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            case (phase)
                0:       travel = TW'(7);
                1:       travel = TW'(TIME_MAX);
                2:       travel = TW'(6);
                3:       travel = '0;
                default: travel = pick_time();
            endcase
            case (phase % 4)
                0:       delay = pick_time();
                1:       delay = TW'(1);
                2:       delay = TW'(TIME_MAX);
                default: delay = '0;
            endcase
            cfg_write(CFG_DURATION, travel);
            cfg_write(CFG_DELAY, delay);
            steady = (phase % 3 == 2);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    // new target followed by a run of ticks toward it
                    send_req(REQ_SET, pick_target(), 1'b0, '0, pick_gap());
                    n++;
                    repeat ($urandom_range(1, 12))
                    begin
                        send_req(REQ_TICK, pick_time(), 1'b0, '0, pick_gap());
                        n++;
                    end
                end
                else
                begin
                    send_req(logic'($urandom_range(0, 1)), TW'($urandom), 1'b0, '0,
                             pick_gap());
                    n++;
                end
            end
            steady = 1'b0;
        end
        drain_wait();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && ramp_expect.size() == 0)
            $display("slew_ramp_auto_return test passed");
        else
            $display("slew_ramp_auto_return test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sra_pkg.sv
rtl/core/sra_div.sv
rtl/core/slew_ramp_auto_return.sv
tb/testbench.sv
